### rtl/core/rotary_position_embedding_top_macros.svh
// Assertion macros for the rotary position embedding block.
// Needs clk and arst_n in the scope of the including module.
`ifndef ROTARY_POSITION_EMBEDDING_TOP_MACROS_SVH
`define ROTARY_POSITION_EMBEDDING_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ROPE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rope: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ROPE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rope: next-cycle check failed");

`endif

### rtl/core/rope_pkg.sv
// Shared types, constants and elaboration-time table builders for the RoPE block.
// No dependencies.
`default_nettype none

package rope_pkg;

	localparam int unsigned HEAD_DIM_DEF   = 128;
	localparam int unsigned THETA_BASE_DEF = 10000;

	localparam int NPAIRS       = 64;
	localparam int PAIR_W       = $clog2(NPAIRS);
	localparam int CORDIC_STEPS = 18;
	localparam int LANE_W       = 16;
	localparam int POS_W        = 16;
	localparam int FREQ_W       = 40;
	localparam int ANGLE_W      = 32;
	localparam int XY_W         = 33;
	localparam int Z_W          = 32;

	localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

	// Arctangents of 2^-i in binary-angle units (one turn = 2^32).
	localparam logic [Z_W-1:0] ATAN_BA [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F
	};

	typedef struct packed {
		logic signed [LANE_W-1:0] q_even;
		logic signed [LANE_W-1:0] q_odd;
		logic signed [LANE_W-1:0] k_even;
		logic signed [LANE_W-1:0] k_odd;
	} lanes_t;

	typedef struct packed {
		lanes_t     lanes;
		logic [1:0] quad;
	} carry_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} rot_t;

	typedef logic [FREQ_W-1:0] freq_tab_t [NPAIRS];

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] b;
		n   = n_in;
		res = '0;
		b   = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 64'd0) begin
			if (n >= res + b) begin
				n   = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Restoring long division, used only while building the table.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Per-pair frequency in turns per position, Q0.40.
	function automatic freq_tab_t build_freq_tab(input int unsigned lanes_per_head,
		input int unsigned theta_base);
		freq_tab_t   tab;
		logic [63:0] t;
		logic [63:0] m;
		logic [63:0] lg;
		logic [63:0] e;
		logic [63:0] ei;
		logic [63:0] f;
		logic [63:0] r;
		logic [63:0] c [31];
		int          n;
		t = 64'(theta_base);
		if (t < 64'd1) t = 64'd1;
		n = 0;
		while ((t >> (n + 1)) != 64'd0) n++;
		m  = (t << 30) >> n;
		lg = 64'(n) << 30;
		for (int k = 1; k <= 30; k++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m  = m >> 1;
				lg = lg | (64'd1 << (30 - k));
			end
		end
		c[0] = '0;
		c[1] = isqrt64(64'd1 << 63);
		for (int k = 2; k <= 30; k++) c[k] = isqrt64(c[k-1] << 32);
		for (int j = 0; j < NPAIRS; j++) begin
			e  = udiv64(lg * 64'd2 * 64'(j), 64'(lanes_per_head));
			ei = e >> 30;
			f  = e & ((64'd1 << 30) - 64'd1);
			r  = 64'd1 << 32;
			for (int k = 1; k <= 30; k++) begin
				if (f[30-k]) r = (r * c[k]) >> 32;
			end
			r = (ei > 64'd32) ? 64'd0 : (r >> ei);
			tab[j] = FREQ_W'((r * INV_TWO_PI_Q32 + (64'd1 << 23)) >> 24);
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

### rtl/core/rope_phase.sv
// Frequency lookup and phase multiply: two pipeline stages ahead of the CORDIC row.
// Depends on rope_pkg.
`default_nettype none

module rope_phase #(
	parameter int unsigned HEAD_DIM   = rope_pkg::HEAD_DIM_DEF,
	parameter int unsigned THETA_BASE = rope_pkg::THETA_BASE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          v_in,
	input  wire logic [rope_pkg::POS_W-1:0]    token_position,
	input  wire logic [rope_pkg::PAIR_W-1:0]   pair_index,
	input  wire rope_pkg::lanes_t              lanes_in,
	output logic                               v_out,
	output logic [rope_pkg::ANGLE_W-1:0]       angle,
	output rope_pkg::lanes_t                   lanes_out
);
	import rope_pkg::*;

	localparam freq_tab_t FreqTab = build_freq_tab(HEAD_DIM, THETA_BASE);

	logic                v_s1;
	logic [FREQ_W-1:0]   freq_s1;
	logic [POS_W-1:0]    pos_s1;
	lanes_t              lanes_s1;
	logic                v_s2;
	logic [ANGLE_W-1:0]  angle_s2;
	lanes_t              lanes_s2;
	logic [FREQ_W-1:0]   phase;

	// phase wraps modulo one turn (2^40)
	assign phase = FREQ_W'(pos_s1) * freq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			freq_s1  <= FreqTab[pair_index];
			pos_s1   <= token_position;
			lanes_s1 <= lanes_in;
			angle_s2 <= phase[FREQ_W-1 -: ANGLE_W];
			lanes_s2 <= lanes_s1;
		end
	end

	assign v_out     = v_s2;
	assign angle     = angle_s2;
	assign lanes_out = lanes_s2;

endmodule

`default_nettype wire

### rtl/core/rope_cordic_cell.sv
// One CORDIC rotation step as a registered cell of the row.
// Depends on rope_pkg.
`default_nettype none

module rope_cordic_cell #(
	parameter int STEP = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire rope_pkg::rot_t    rot_in,
	input  wire rope_pkg::carry_t  carry_in,
	output logic                   v_out,
	output rope_pkg::rot_t         rot_out,
	output rope_pkg::carry_t       carry_out
);
	import rope_pkg::*;

	localparam logic signed [Z_W-1:0] Atan = signed'(ATAN_BA[STEP]);

	logic   v_q;
	rot_t   rot_q;
	carry_t carry_q;
	rot_t   rot_nx;

	// shifts round toward minus infinity
	always_comb begin
		if (rot_in.z >= 0) begin
			rot_nx.x = rot_in.x - (rot_in.y >>> STEP);
			rot_nx.y = rot_in.y + (rot_in.x >>> STEP);
			rot_nx.z = rot_in.z - Atan;
		end else begin
			rot_nx.x = rot_in.x + (rot_in.y >>> STEP);
			rot_nx.y = rot_in.y - (rot_in.x >>> STEP);
			rot_nx.z = rot_in.z + Atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q   <= rot_nx;
			carry_q <= carry_in;
		end
	end

	assign v_out     = v_q;
	assign rot_out   = rot_q;
	assign carry_out = carry_q;

endmodule

`default_nettype wire

### rtl/core/rope_rotate.sv
// Quadrant fold, lane products, rounding and saturation: two pipeline stages.
// Depends on rope_pkg.
`default_nettype none

module rope_rotate (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                v_in,
	input  wire logic signed [rope_pkg::XY_W-1:0]    x_in,
	input  wire logic signed [rope_pkg::XY_W-1:0]    y_in,
	input  wire rope_pkg::carry_t                    carry_in,
	output logic                                     v_out,
	output logic signed [rope_pkg::LANE_W-1:0]       q_even_rot,
	output logic signed [rope_pkg::LANE_W-1:0]       q_odd_rot,
	output logic signed [rope_pkg::LANE_W-1:0]       k_even_rot,
	output logic signed [rope_pkg::LANE_W-1:0]       k_odd_rot
);
	import rope_pkg::*;

	localparam int PROD_W = LANE_W + XY_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam logic signed [ACC_W-1:0] Rnd    = ACC_W'(64'sd536870912);
	localparam logic signed [ACC_W-1:0] SatMax = ACC_W'(64'sd32767);
	localparam logic signed [ACC_W-1:0] SatMin = ACC_W'(-64'sd32768);

	logic signed [XY_W-1:0]   cs;
	logic signed [XY_W-1:0]   sn;
	logic signed [PROD_W-1:0] qe_c_s1, qo_s_s1, qe_s_s1, qo_c_s1;
	logic signed [PROD_W-1:0] ke_c_s1, ko_s_s1, ke_s_s1, ko_c_s1;
	logic                     v_s1;
	logic                     v_q;
	logic signed [LANE_W-1:0] qe_q, qo_q, ke_q, ko_q;

	function automatic logic signed [LANE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] v;
		v = (acc + Rnd) >>> 30;
		if (v > SatMax) v = SatMax;
		if (v < SatMin) v = SatMin;
		return v[LANE_W-1:0];
	endfunction

	// fold the first-quadrant result into the selected quadrant
	always_comb begin
		unique case (carry_in.quad)
			2'd0: begin cs = x_in;  sn = y_in;  end
			2'd1: begin cs = -y_in; sn = x_in;  end
			2'd2: begin cs = -x_in; sn = -y_in; end
			2'd3: begin cs = y_in;  sn = -x_in; end
			default: begin cs = x_in; sn = y_in; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_q  <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qe_c_s1 <= PROD_W'(carry_in.lanes.q_even) * PROD_W'(cs);
			qo_s_s1 <= PROD_W'(carry_in.lanes.q_odd) * PROD_W'(sn);
			qe_s_s1 <= PROD_W'(carry_in.lanes.q_even) * PROD_W'(sn);
			qo_c_s1 <= PROD_W'(carry_in.lanes.q_odd) * PROD_W'(cs);
			ke_c_s1 <= PROD_W'(carry_in.lanes.k_even) * PROD_W'(cs);
			ko_s_s1 <= PROD_W'(carry_in.lanes.k_odd) * PROD_W'(sn);
			ke_s_s1 <= PROD_W'(carry_in.lanes.k_even) * PROD_W'(sn);
			ko_c_s1 <= PROD_W'(carry_in.lanes.k_odd) * PROD_W'(cs);
			qe_q <= round_sat(ACC_W'(qe_c_s1) - ACC_W'(qo_s_s1));
			qo_q <= round_sat(ACC_W'(qe_s_s1) + ACC_W'(qo_c_s1));
			ke_q <= round_sat(ACC_W'(ke_c_s1) - ACC_W'(ko_s_s1));
			ko_q <= round_sat(ACC_W'(ke_s_s1) + ACC_W'(ko_c_s1));
		end
	end

	assign v_out      = v_q;
	assign q_even_rot = qe_q;
	assign q_odd_rot  = qo_q;
	assign k_even_rot = ke_q;
	assign k_odd_rot  = ko_q;

endmodule

`default_nettype wire

### rtl/core/rotary_position_embedding_top.sv
// Top level of the interleaved rotary position embedding block.
// Depends on rope_pkg, rope_phase, rope_cordic_cell, rope_rotate and the macros header.
`default_nettype none
`include "rotary_position_embedding_top_macros.svh"

// Rotates one query pair and one key pair per transfer by the angle
// token_position * THETA_BASE^(-2j/HEAD_DIM), j = pair_index. Values are
// Q4.12 and saturate. One item enters per cycle unless the output stalls.
// The pipeline holds two stages for frequency lookup and phase multiply, a row of
// 18 CORDIC cells (one rotation step each), one product stage and one
// round/saturate stage that is also the output register. The whole pipeline
// advances whenever the output register is empty or being drained; a one-deep
// skid register on the input side keeps in_ready a plain flop, so no path
// runs from out_ready to in_ready. The frequency table is built at
// elaboration from HEAD_DIM and THETA_BASE; there is no start-up sweep.

module rotary_position_embedding_top #(
	parameter int unsigned HEAD_DIM   = rope_pkg::HEAD_DIM_DEF,
	parameter int unsigned THETA_BASE = rope_pkg::THETA_BASE_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [rope_pkg::POS_W-1:0]           token_position,
	input  wire logic [rope_pkg::PAIR_W-1:0]          pair_index,
	input  wire logic signed [rope_pkg::LANE_W-1:0]   q_even,
	input  wire logic signed [rope_pkg::LANE_W-1:0]   q_odd,
	input  wire logic signed [rope_pkg::LANE_W-1:0]   k_even,
	input  wire logic signed [rope_pkg::LANE_W-1:0]   k_odd,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [rope_pkg::LANE_W-1:0]        q_even_rot,
	output logic signed [rope_pkg::LANE_W-1:0]        q_odd_rot,
	output logic signed [rope_pkg::LANE_W-1:0]        k_even_rot,
	output logic signed [rope_pkg::LANE_W-1:0]        k_odd_rot
);
	import rope_pkg::*;

	// advance the whole pipeline when the output slot is free or drains now
	logic                adv;
	// input skid register
	logic                skid_v_q;
	logic [POS_W-1:0]    skid_pos_q;
	logic [PAIR_W-1:0]   skid_pair_q;
	lanes_t              skid_lanes_q;
	// front-end feed
	lanes_t              in_lanes;
	logic                feed_v;
	logic [POS_W-1:0]    feed_pos;
	logic [PAIR_W-1:0]   feed_pair;
	lanes_t              feed_lanes;
	// phase stage outputs
	logic                ph_v;
	logic [ANGLE_W-1:0]  ph_angle;
	lanes_t              ph_lanes;
	// CORDIC row links
	logic                cell_v     [CORDIC_STEPS+1];
	rot_t                cell_rot   [CORDIC_STEPS+1];
	carry_t              cell_carry [CORDIC_STEPS+1];

	assign adv      = !out_valid || out_ready;
	assign in_ready = !skid_v_q;
	assign in_lanes = '{q_even: q_even, q_odd: q_odd, k_even: k_even, k_odd: k_odd};

	// A parked item goes first; while one is parked no new transfer is taken.
	assign feed_v     = skid_v_q || in_valid;
	assign feed_pos   = skid_v_q ? skid_pos_q   : token_position;
	assign feed_pair  = skid_v_q ? skid_pair_q  : pair_index;
	assign feed_lanes = skid_v_q ? skid_lanes_q : in_lanes;

	// Park a transfer that arrives during a stall; drop the parked item once it moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (adv) begin
			skid_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && in_valid && in_ready) begin
			skid_pos_q   <= token_position;
			skid_pair_q  <= pair_index;
			skid_lanes_q <= in_lanes;
		end
	end

	rope_phase #(
		.HEAD_DIM  (HEAD_DIM),
		.THETA_BASE(THETA_BASE)
	) u_phase (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.v_in          (feed_v),
		.token_position(feed_pos),
		.pair_index    (feed_pair),
		.lanes_in      (feed_lanes),
		.v_out         (ph_v),
		.angle         (ph_angle),
		.lanes_out     (ph_lanes)
	);

	// Start the row at (gain, 0) with the residual angle inside the quadrant;
	// the quadrant itself rides along and is folded in after the last cell.
	assign cell_v[0]     = ph_v;
	assign cell_rot[0]   = '{x: CORDIC_GAIN_Q30, y: '0, z: {2'b00, ph_angle[ANGLE_W-3:0]}};
	assign cell_carry[0] = '{lanes: ph_lanes, quad: ph_angle[ANGLE_W-1 -: 2]};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		rope_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.v_in     (cell_v[i]),
			.rot_in   (cell_rot[i]),
			.carry_in (cell_carry[i]),
			.v_out    (cell_v[i+1]),
			.rot_out  (cell_rot[i+1]),
			.carry_out(cell_carry[i+1])
		);
	end

	rope_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.v_in      (cell_v[CORDIC_STEPS]),
		.x_in      (cell_rot[CORDIC_STEPS].x),
		.y_in      (cell_rot[CORDIC_STEPS].y),
		.carry_in  (cell_carry[CORDIC_STEPS]),
		.v_out     (out_valid),
		.q_even_rot(q_even_rot),
		.q_odd_rot (q_odd_rot),
		.k_even_rot(k_even_rot),
		.k_odd_rot (k_odd_rot)
	);

	// Skid register behavior under stall and release.
	`ROPE_ASSERT_NEXT(a_skid_holds, skid_v_q && !adv, skid_v_q && $stable(skid_pos_q))
	`ROPE_ASSERT_NEXT(a_skid_drains, skid_v_q && adv, !skid_v_q)
	`ROPE_ASSERT_NEXT(a_skid_fills, in_valid && in_ready && !adv, skid_v_q)
	`ROPE_ASSERT_SAME(a_parked_first, skid_v_q, feed_v && feed_pos == skid_pos_q)

endmodule

`default_nettype wire

### test/tb_rotary_position_embedding_top.sv
// Self-checking testbench for rotary_position_embedding_top.
// It predicts each rotated query/key pair with its own fixed-point model.
// Needs rope_pkg and the block's RTL, nothing else.
`timescale 1ns / 100ps

module tb_rotary_position_embedding_top;

	localparam int unsigned HEAD_DIM   = rope_pkg::HEAD_DIM_DEF;
	localparam int unsigned THETA_BASE = rope_pkg::THETA_BASE_DEF;
	localparam int          RATE_PAIRS = 64;
	localparam int          ROT_STEPS  = 18;
	localparam int          RANDOM_PAIRS = 1050;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          SHOW_LIMIT   = 10;
	localparam int          HOLD_AFTER   = 500;
	localparam int          HOLD_CYCLES  = 400;

	// Unit vector at angle zero, pre-scaled by the inverse CORDIC gain (Q.30).
	localparam longint GAIN_Q30 = 64'sd652032874;
	// 2^32 / (2*pi), rounded: converts radians per position to turns.
	localparam longint unsigned TURNS_PER_RAD_Q32 = 64'd683565276;
	localparam longint LANE_MAX = 64'sd32767;
	localparam longint LANE_MIN = -64'sd32768;

	// Arctangent of 2^-i in binary-angle units, one turn = 2^32.
	localparam longint ARC_STEP [ROT_STEPS] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
		'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F
	};

	typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_e;

	typedef struct packed {
		logic [rope_pkg::POS_W-1:0]  pos;
		logic [rope_pkg::PAIR_W-1:0] pair;
		rope_pkg::lanes_t            lanes;
	} pair_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                                    in_valid       = 1'b0;
	logic                                    in_ready;
	logic [rope_pkg::POS_W-1:0]              token_position = '0;
	logic [rope_pkg::PAIR_W-1:0]             pair_index     = '0;
	logic signed [rope_pkg::LANE_W-1:0]      q_even         = '0;
	logic signed [rope_pkg::LANE_W-1:0]      q_odd          = '0;
	logic signed [rope_pkg::LANE_W-1:0]      k_even         = '0;
	logic signed [rope_pkg::LANE_W-1:0]      k_odd          = '0;
	logic                                    out_valid;
	logic                                    out_ready      = 1'b0;
	logic signed [rope_pkg::LANE_W-1:0]      q_even_rot;
	logic signed [rope_pkg::LANE_W-1:0]      q_odd_rot;
	logic signed [rope_pkg::LANE_W-1:0]      k_even_rot;
	logic signed [rope_pkg::LANE_W-1:0]      k_odd_rot;

	// Per-pair rotation rate in turns per position, Q0.40.
	logic [39:0] turn_rate [RATE_PAIRS];

	pair_item_t       pair_q[$];      // items waiting to be offered
	rope_pkg::lanes_t rotated_q[$];   // expected rotated lanes, oldest first

	int  cycles      = 0;
	int  n_in        = 0;
	int  n_out       = 0;
	int  n_directed  = 0;
	int  n_sat_lanes = 0;
	int  n_in_stall  = 0;
	int  n_errors    = 0;
	bit  in_took     = 1'b0;

	// Sender burst state and receiver stall state.
	int   burst_left  = 0;
	int   gap_left    = 0;
	int   stall_mode  = 0;
	int   stall_phase = 0;
	int   hold_left   = 0;
	bit   hold_done   = 1'b0;
	logic rdy_pick;

	rotary_position_embedding_top #(
		.HEAD_DIM  (HEAD_DIM),
		.THETA_BASE(THETA_BASE)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.token_position(token_position),
		.pair_index    (pair_index),
		.q_even        (q_even),
		.q_odd         (q_odd),
		.k_even        (k_even),
		.k_odd         (k_odd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.q_even_rot    (q_even_rot),
		.q_odd_rot     (q_odd_rot),
		.k_even_rot    (k_even_rot),
		.k_odd_rot     (k_odd_rot)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Floor square root, found one result bit at a time from the top.
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned acc;
		longint unsigned trial;
		acc = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = acc | (64'd1 << b);
			if (trial * trial <= v) acc = trial;
		end
		return acc;
	endfunction

	// Round half up from Q.42 to Q.12, then clamp to the lane range.
	function automatic logic signed [15:0] round_clamp(input longint acc);
		longint v;
		v = (acc + 64'sd536870912) >>> 30;
		if (v > LANE_MAX) v = LANE_MAX;
		if (v < LANE_MIN) v = LANE_MIN;
		return v[15:0];
	endfunction

	// Expected rotated lanes for one pair item.
	function automatic rope_pkg::lanes_t rotate_pair(input pair_item_t it);
		logic [63:0]      phase;
		logic [31:0]      angle;
		longint           x;
		longint           y;
		longint           z;
		longint           nx;
		longint           cs;
		longint           sn;
		longint           qe;
		longint           qo;
		longint           ke;
		longint           ko;
		rope_pkg::lanes_t res;
		phase = (64'(it.pos) * 64'(turn_rate[it.pair])) & 64'hFF_FFFF_FFFF;
		angle = phase[39:8];
		x = GAIN_Q30;
		y = 0;
		z = longint'(angle[29:0]);
		// Steer the residual angle toward zero, one micro-rotation per step.
		for (int i = 0; i < ROT_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - ARC_STEP[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + ARC_STEP[i];
			end
			x = nx;
		end
		// Fold the quadrant back in.
		case (quadrant_e'(angle[31:30]))
			QUAD_I: begin
				cs = x;
				sn = y;
			end
			QUAD_II: begin
				cs = -y;
				sn = x;
			end
			QUAD_III: begin
				cs = -x;
				sn = -y;
			end
			default: begin
				cs = y;
				sn = -x;
			end
		endcase
		qe = longint'(it.lanes.q_even);
		qo = longint'(it.lanes.q_odd);
		ke = longint'(it.lanes.k_even);
		ko = longint'(it.lanes.k_odd);
		res.q_even = round_clamp(qe * cs - qo * sn);
		res.q_odd  = round_clamp(qe * sn + qo * cs);
		res.k_even = round_clamp(ke * cs - ko * sn);
		res.k_odd  = round_clamp(ke * sn + ko * cs);
		return res;
	endfunction

	// Lane value for random items: extremes, values within +/-1.0, near-zero values and full range.
	function automatic logic signed [15:0] pick_lane();
		logic signed [15:0] v;
		case ($urandom_range(0, 7))
			0:       v = 16'sh7FFF;
			1:       v = 16'sh8000;
			2:       v = 16'(int'($urandom_range(0, 8192)) - 4096);
			3:       v = ($urandom_range(0, 1) != 0) ? 16'sh0000 : 16'shFFFF;
			default: v = 16'($urandom());
		endcase
		return v;
	endfunction

	function automatic pair_item_t make_pair(input int pos, input int pair,
		input int qe, input int qo, input int ke, input int ko);
		pair_item_t it;
		it.pos          = 16'(pos);
		it.pair         = 6'(pair);
		it.lanes.q_even = 16'(qe);
		it.lanes.q_odd  = 16'(qo);
		it.lanes.k_even = 16'(ke);
		it.lanes.k_odd  = 16'(ko);
		return it;
	endfunction

	// Build the rotation-rate table: log2 of the base by repeated squaring,
	// then 2^-exponent as a product of square-root factors.
	initial begin
		longint unsigned base;
		longint unsigned mant;
		longint unsigned log2q;
		longint unsigned expo;
		longint unsigned whole;
		logic [63:0]     frac;
		longint unsigned r;
		longint unsigned root [31];
		int              msb;
		base = 64'(THETA_BASE);
		if (base < 1) base = 1;
		msb = 0;
		while ((base >> (msb + 1)) != 0) msb++;
		mant  = (base << 30) >> msb;
		log2q = 64'(msb) << 30;
		for (int k = 1; k <= 30; k++) begin
			mant = (mant * mant) >> 30;
			if (mant >= (64'd1 << 31)) begin
				mant  = mant >> 1;
				log2q = log2q | (64'd1 << (30 - k));
			end
		end
		// root[k] = 2^(-2^-k) in Q0.32.
		root[0] = 0;
		root[1] = root_floor(64'd1 << 63);
		for (int k = 2; k <= 30; k++) root[k] = root_floor(root[k-1] << 32);
		for (int j = 0; j < RATE_PAIRS; j++) begin
			expo  = (log2q * 64'd2 * 64'(j)) / 64'(HEAD_DIM);
			whole = expo >> 30;
			frac  = expo & ((64'd1 << 30) - 64'd1);
			r     = 64'd1 << 32;
			for (int k = 1; k <= 30; k++) begin
				if (frac[30-k]) r = (r * root[k]) >> 32;
			end
			r = (whole > 32) ? 64'd0 : (r >> whole);
			turn_rate[j] = 40'((r * TURNS_PER_RAD_Q32 + (64'd1 << 23)) >> 24);
		end
	end

	// Sender: offer the next pending item at the falling edge, in bursts of
	// random length with random gaps. Hold valid and payload until the
	// transfer happens.
	always @(negedge clk) begin
		pair_item_t nxt;
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pair_q.size() != 0) begin
				nxt = pair_q.pop_front();
				in_valid       <= 1'b1;
				token_position <= nxt.pos;
				pair_index     <= nxt.pair;
				q_even         <= nxt.lanes.q_even;
				q_odd          <= nxt.lanes.q_odd;
				k_even         <= nxt.lanes.k_even;
				k_odd          <= nxt.lanes.k_odd;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					// A quarter of the bursts follow straight on with no gap.
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long hold-off of the receiver, once, while the sender still has plenty
	// queued: the pipeline fills and in_ready has to drop.
	always @(negedge clk) begin
		if (!hold_done && n_in >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: switch among stall patterns at random intervals.
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_mode  <= $urandom_range(0, 3);
			stall_phase <= $urandom_range(20, 150);
		end else begin
			stall_phase <= stall_phase - 1;
		end
		case (stall_mode)
			0:       rdy_pick = 1'b1;
			1:       rdy_pick = ($urandom_range(0, 1) != 0);
			2:       rdy_pick = ((cycles % 4) != 0);
			default: rdy_pick = ($urandom_range(0, 7) == 0);
		endcase
		out_ready <= (hold_left == 0) && rdy_pick;
	end

	// Monitor: record input transfers, predict, and check output transfers
	// against the oldest expectation.
	always @(posedge clk) begin
		pair_item_t       seen;
		rope_pkg::lanes_t want;
		rope_pkg::lanes_t got;
		cycles++;
		in_took = arst_n && in_valid && in_ready;
		if (arst_n && in_valid && !in_ready) n_in_stall++;
		if (in_took) begin
			seen = make_pair(token_position, pair_index, q_even, q_odd, k_even, k_odd);
			want = rotate_pair(seen);
			rotated_q.push_back(want);
			n_in++;
			if (want.q_even == 16'sh7FFF || want.q_even == 16'sh8000) n_sat_lanes++;
			if (want.q_odd == 16'sh7FFF || want.q_odd == 16'sh8000) n_sat_lanes++;
			if (want.k_even == 16'sh7FFF || want.k_even == 16'sh8000) n_sat_lanes++;
			if (want.k_odd == 16'sh7FFF || want.k_odd == 16'sh8000) n_sat_lanes++;
		end
		if (arst_n && out_valid && out_ready) begin
			got.q_even = q_even_rot;
			got.q_odd  = q_odd_rot;
			got.k_even = k_even_rot;
			got.k_odd  = k_odd_rot;
			if (rotated_q.size() == 0) begin
				n_errors++;
				if (n_errors <= SHOW_LIMIT)
					$display("[%0d] result with nothing expected: %0d %0d %0d %0d", cycles,
						got.q_even, got.q_odd, got.k_even, got.k_odd);
			end else begin
				want = rotated_q.pop_front();
				if (got.q_even !== want.q_even || got.q_odd !== want.q_odd ||
					got.k_even !== want.k_even || got.k_odd !== want.k_odd) begin
					n_errors++;
					if (n_errors <= SHOW_LIMIT)
						$display("[%0d] result %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
							cycles, n_out, want.q_even, want.q_odd, want.k_even, want.k_odd,
							got.q_even, got.q_odd, got.k_even, got.k_odd);
				end
			end
			n_out++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				rotated_q.size());
			$display("rotary_position_embedding_top verification failed");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int pos;
		// Directed part: zero angle, every quadrant, top position, the last pair
		// of the head, extremes of every lane and saturating rotations.
		pair_q.push_back(make_pair(0, 0, 4096, 0, -4096, 4096));
		pair_q.push_back(make_pair(0, 0, 32767, -32768, -32768, 32767));
		pair_q.push_back(make_pair(0, 63, 0, 0, 0, 0));
		pair_q.push_back(make_pair(1, 0, 4096, 0, 0, 4096));
		pair_q.push_back(make_pair(2, 0, 4096, 0, 0, 4096));
		pair_q.push_back(make_pair(4, 0, 4096, 0, 0, 4096));
		pair_q.push_back(make_pair(5, 0, 4096, 0, 0, 4096));
		pair_q.push_back(make_pair(1, 0, 32767, 32767, -32768, -32768));
		pair_q.push_back(make_pair(1, 0, -32768, 32767, 32767, -32768));
		pair_q.push_back(make_pair(65535, 0, 32767, -32768, 12345, -54321));
		pair_q.push_back(make_pair(65535, 63, 32767, 32767, -32768, -32768));
		pair_q.push_back(make_pair(65535, 31, -1, 1, -32768, 32767));
		pair_q.push_back(make_pair(65535, 32, 20000, -20000, 8192, 8192));
		pair_q.push_back(make_pair(65535, 40, -32768, -32768, 32767, 32767));
		pair_q.push_back(make_pair(32768, 48, 4096, 4096, -4096, -4096));
		pair_q.push_back(make_pair(32768, 1, 32767, 0, 0, 32767));
		pair_q.push_back(make_pair(3, 0, -1, -1, -1, -1));
		pair_q.push_back(make_pair(100, 16, 21845, -21846, 10922, -10923));
		pair_q.push_back(make_pair(43690, 42, 1, -1, 32767, -32768));
		pair_q.push_back(make_pair(21845, 21, -32768, 0, 0, -32768));
		n_directed = pair_q.size();
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			case ($urandom_range(0, 7))
				0, 1:    pos = $urandom_range(0, 15);
				2:       pos = ($urandom_range(0, 1) != 0) ? 65535 : 32768;
				default: pos = $urandom_range(0, 65535);
			endcase
			pair_q.push_back(make_pair(pos, $urandom_range(0, 63), pick_lane(), pick_lane(),
				pick_lane(), pick_lane()));
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: all items transferred, then all results back, then a margin
		// longer than the pipeline depth to catch stray results.
		while (pair_q.size() != 0 || in_valid) @(posedge clk);
		while (rotated_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pair transfers (%0d directed), %0d results, %0d saturated lanes",
			n_in, n_directed, n_out, n_sat_lanes);
		$display("input held off on %0d cycles, %0d mismatches in %0d cycles",
			n_in_stall, n_errors, cycles);
		if (n_errors == 0 && rotated_q.size() == 0) begin
			$display("rotary_position_embedding_top verification clean");
		end else begin
			$display("rotary_position_embedding_top verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rope_pkg.sv
rtl/core/rope_phase.sv
rtl/core/rope_cordic_cell.sv
rtl/core/rope_rotate.sv
rtl/core/rotary_position_embedding_top.sv
test/tb_rotary_position_embedding_top.sv
